### rtl/rbpb_pkg.sv
// ----------------------------------------------------------------------------
// rbpb_pkg
// Shared constants, types and helpers for the row bitmap to page byte core.
// ----------------------------------------------------------------------------
`default_nettype none

package rbpb_pkg;

	localparam int DISPLAY_WIDTH = 128;
	localparam int PAGE_COUNT    = 8;

	localparam int PIX_W      = 8;
	localparam int BAND_ROWS  = 8;
	localparam int ROW_BYTES  = DISPLAY_WIDTH / PIX_W;
	localparam int FRAME_ROWS = PAGE_COUNT * BAND_ROWS;
	localparam int POS_W      = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
	localparam int ROW_W      = $clog2(FRAME_ROWS);
	localparam int LANE_W     = 3;
	localparam int STORE_W    = (BAND_ROWS - 1) * PIX_W;
	localparam int COLS_W     = BAND_ROWS * PIX_W;
	localparam int PAGE_W     = 3;
	localparam int COL_W      = 7;

	// one byte-lane write into the line store
	typedef struct packed {
		logic              en;
		logic [POS_W-1:0]  addr;
		logic [LANE_W-1:0] lane;
		logic [PIX_W-1:0]  data;
	} wr_req_t;

	// Builds the eight column bytes of a band: byte p is column p (MSB pixel
	// first), bit r of it is band row r. Row 7 comes straight from the input.
	function automatic logic [COLS_W-1:0] gather_cols(input logic [STORE_W-1:0] upper,
			input logic [PIX_W-1:0] last_row);
		logic [COLS_W-1:0] cols;
		cols = '0;
		for (int p = 0; p < PIX_W; p++) begin
			for (int r = 0; r < BAND_ROWS - 1; r++) begin
				cols[p*PIX_W + r] = upper[r*PIX_W + (PIX_W - 1 - p)];
			end
			cols[p*PIX_W + BAND_ROWS - 1] = last_row[PIX_W - 1 - p];
		end
		return cols;
	endfunction

endpackage

`default_nettype wire

### rtl/rbpb_if.sv
// ----------------------------------------------------------------------------
// rbpb_if
// Valid/ready channels for bitmap bytes in and page bytes out.
// ----------------------------------------------------------------------------
`default_nettype none

interface rbpb_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] bitmap_byte;

	modport source (output valid, output bitmap_byte, input ready);
	modport sink (input valid, input bitmap_byte, output ready);
endinterface

interface rbpb_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] column_byte;
	logic [2:0] page_number;
	logic [6:0] column_number;
	logic       last_of_run;
	logic       last_of_frame;

	modport source (output valid, output column_byte, output page_number,
		output column_number, output last_of_run, output last_of_frame, input ready);
	modport sink (input valid, input column_byte, input page_number,
		input column_number, input last_of_run, input last_of_frame, output ready);
endinterface

`default_nettype wire

### rtl/rbpb_line_store.sv
// ----------------------------------------------------------------------------
// rbpb_line_store
// Line store for rows 0..6 of the current band: byte-lane writes, one
// registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rbpb_line_store (
	input  wire logic                          clk,
	input  wire rbpb_pkg::wr_req_t             wr,
	input  wire logic                          rd_en,
	input  wire logic [rbpb_pkg::POS_W-1:0]    rd_addr,
	output logic      [rbpb_pkg::STORE_W-1:0]  rd_data
);

	logic [rbpb_pkg::STORE_W-1:0] mem [rbpb_pkg::ROW_BYTES];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr][wr.lane*rbpb_pkg::PIX_W +: rbpb_pkg::PIX_W] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

### rtl/row_bitmap_to_page_bytes_core.sv
// ----------------------------------------------------------------------------
// row_bitmap_to_page_bytes_core
// Row-major 1bpp bitmap in, vertical page bytes out.
// ----------------------------------------------------------------------------
// Bytes of rows 0..6 of each band are written into the line store and
// produce nothing. A byte of a band's eighth row reads the store entry
// of its column group and is turned into eight column bytes, sent one
// per cycle while the output is ready, last_of_run on the eighth and
// last_of_frame on the frame's final byte. The output serializer sets
// the rate: while it is busy with a row-7 item, row 0..6 items keep
// being accepted; a row-7 item that finds the read stage still holding
// the next item waits until the serializer frees up. Counters wrap at the
// end of a frame. No clearing pass after reset.
`default_nettype none

module row_bitmap_to_page_bytes_core (
	input  wire logic clk,
	input  wire logic arst_n,
	rbpb_in_if.sink   bitmap,
	rbpb_out_if.source page_bytes
);

	logic [rbpb_pkg::ROW_W-1:0] row_q;
	logic [rbpb_pkg::POS_W-1:0] pos_q;

	logic row7, accept, frame_end;
	rbpb_pkg::wr_req_t wr;
	logic [rbpb_pkg::STORE_W-1:0] rd_data;

	// read stage
	logic                        valid_s1;
	logic [rbpb_pkg::PIX_W-1:0]  last_s1;
	logic [rbpb_pkg::PAGE_W-1:0] page_s1;
	logic [rbpb_pkg::POS_W-1:0]  pos_s1;
	logic                        fend_s1;
	logic                        s1_adv;

	// serializer
	logic                         ser_valid_q;
	logic [2:0]                   idx_q;
	logic [rbpb_pkg::COLS_W-1:0]  cols_q;
	logic [rbpb_pkg::PAGE_W-1:0]  page_q;
	logic [rbpb_pkg::POS_W-1:0]   spos_q;
	logic                         fend_q;
	logic                         beat, beat_last;

	assign row7      = &row_q[2:0];
	assign frame_end = (row_q == rbpb_pkg::ROW_W'(rbpb_pkg::FRAME_ROWS - 1)) &&
		(pos_q == rbpb_pkg::POS_W'(rbpb_pkg::ROW_BYTES - 1));

	assign beat      = ser_valid_q && page_bytes.ready;
	assign beat_last = beat && (idx_q == 3'd7);
	assign s1_adv    = valid_s1 && (!ser_valid_q || beat_last);

	assign bitmap.ready = !row7 || !valid_s1 || s1_adv;
	assign accept       = bitmap.valid && bitmap.ready;

	always_comb begin
		wr.en   = accept && !row7;
		wr.addr = pos_q;
		wr.lane = row_q[2:0];
		wr.data = bitmap.bitmap_byte;
	end

	rbpb_line_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (accept && row7),
		.rd_addr (pos_q),
		.rd_data (rd_data)
	);

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			pos_q <= '0;
		end else if (accept) begin
			if (pos_q == rbpb_pkg::POS_W'(rbpb_pkg::ROW_BYTES - 1)) begin
				pos_q <= '0;
				if (row_q == rbpb_pkg::ROW_W'(rbpb_pkg::FRAME_ROWS - 1)) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + 1'b1;
				end
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	// read stage control and payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept && row7) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && row7) begin
			last_s1 <= bitmap.bitmap_byte;
			page_s1 <= rbpb_pkg::PAGE_W'(32'(row_q) >> 3);
			pos_s1  <= pos_q;
			fend_s1 <= frame_end;
		end
	end

	// serializer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (s1_adv) begin
			ser_valid_q <= 1'b1;
			idx_q       <= '0;
		end else if (beat) begin
			if (beat_last) begin
				ser_valid_q <= 1'b0;
			end
			idx_q <= idx_q + 1'b1;
		end
	end

	// serializer payload: column bytes shift out low byte first
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			cols_q <= rbpb_pkg::gather_cols(rd_data, last_s1);
			page_q <= page_s1;
			spos_q <= pos_s1;
			fend_q <= fend_s1;
		end else if (beat) begin
			cols_q <= cols_q >> rbpb_pkg::PIX_W;
		end
	end

	assign page_bytes.valid         = ser_valid_q;
	assign page_bytes.column_byte   = cols_q[rbpb_pkg::PIX_W-1:0];
	assign page_bytes.page_number   = page_q;
	assign page_bytes.column_number = rbpb_pkg::COL_W'({spos_q, idx_q});
	assign page_bytes.last_of_run   = (idx_q == 3'd7);
	assign page_bytes.last_of_frame = (idx_q == 3'd7) && fend_q;

endmodule

`default_nettype wire

### dv/row_bitmap_to_page_bytes_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// row_bitmap_to_page_bytes_core_test
// Streams row-major bitmap bytes through the core and checks every page byte
// against an in-bench transpose predictor. Both channels idle at random, and
// the output side also holds off for long stretches so the core backs up.
// ----------------------------------------------------------------------------

module row_bitmap_to_page_bytes_core_test;

	localparam int TOTAL_ITEMS = 410;
	localparam int LONG_HOLD   = 400;

	typedef struct packed {
		logic [7:0] column_byte;
		logic [2:0] page_number;
		logic [6:0] column_number;
		logic       last_of_run;
		logic       last_of_frame;
	} page_byte_t;

	class page_byte_scoreboard;
		logic [rbpb_pkg::STORE_W-1:0] band_rows[rbpb_pkg::ROW_BYTES];
		int unsigned        row_idx;
		int unsigned        group_idx;
		page_byte_t         pending_q[$];
		int                 mismatches;
		int                 checked;
		int                 frame_ends;

		function new();
			foreach (band_rows[i]) band_rows[i] = '0;
			row_idx    = 0;
			group_idx  = 0;
			mismatches = 0;
			checked    = 0;
			frame_ends = 0;
		endfunction

		// accepted bitmap byte: store rows 0..6, transpose on row 7
		function void note_byte(logic [7:0] b);
			page_byte_t   pb;
			int unsigned  band_row;
			band_row = row_idx % rbpb_pkg::BAND_ROWS;
			if (band_row < rbpb_pkg::BAND_ROWS - 1) begin
				band_rows[group_idx][band_row*rbpb_pkg::PIX_W +: rbpb_pkg::PIX_W] = b;
			end else begin
				for (int p = 0; p < rbpb_pkg::PIX_W; p++) begin
					for (int r = 0; r < rbpb_pkg::BAND_ROWS - 1; r++)
						pb.column_byte[r] =
							band_rows[group_idx][r*rbpb_pkg::PIX_W + (rbpb_pkg::PIX_W-1-p)];
					pb.column_byte[7] = b[rbpb_pkg::PIX_W-1-p];
					pb.page_number    = 3'(row_idx / rbpb_pkg::BAND_ROWS);
					pb.column_number  = 7'(group_idx * rbpb_pkg::PIX_W + p);
					pb.last_of_run    = (p == rbpb_pkg::PIX_W - 1);
					pb.last_of_frame  = (p == rbpb_pkg::PIX_W - 1)
						&& (row_idx == rbpb_pkg::FRAME_ROWS - 1)
						&& (group_idx == rbpb_pkg::ROW_BYTES - 1);
					pending_q.push_back(pb);
				end
			end
			group_idx++;
			if (group_idx == rbpb_pkg::ROW_BYTES) begin
				group_idx = 0;
				row_idx++;
				if (row_idx == rbpb_pkg::FRAME_ROWS) row_idx = 0;
			end
		endfunction

		function void report(string what, page_byte_t got, page_byte_t exp);
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t: %s: got byte=%h page=%0d col=%0d run=%b frame=%b",
					$time, what, got.column_byte, got.page_number, got.column_number,
					got.last_of_run, got.last_of_frame);
				$display("    expected byte=%h page=%0d col=%0d run=%b frame=%b",
					exp.column_byte, exp.page_number, exp.column_number,
					exp.last_of_run, exp.last_of_frame);
			end
		endfunction

		function void check_result(page_byte_t got);
			page_byte_t exp;
			if (pending_q.size() == 0) begin
				report("unexpected page byte", got, '0);
				return;
			end
			exp = pending_q.pop_front();
			checked++;
			if (got.last_of_frame) frame_ends++;
			if (got.column_byte !== exp.column_byte || got.page_number !== exp.page_number
					|| got.column_number !== exp.column_number
					|| got.last_of_run !== exp.last_of_run
					|| got.last_of_frame !== exp.last_of_frame)
				report("page byte mismatch", got, exp);
		endfunction

		function int pending();
			return pending_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   no_idle;
	int   bytes_sent;
	int   long_holds;

	page_byte_scoreboard sb;

	rbpb_in_if  bitmap();
	rbpb_out_if page_bytes();

	row_bitmap_to_page_bytes_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.bitmap    (bitmap),
		.page_bytes(page_bytes)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// mostly short gaps, a few long ones, none while bursting
	function automatic int pick_gap();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// caller is at a rising edge; returns at the edge the item is accepted
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			bitmap.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		bitmap.valid       <= 1'b1;
		bitmap.bitmap_byte <= b;
		do @(posedge clk); while (!bitmap.ready);
		sb.note_byte(b);
		bytes_sent++;
	endtask

	// output side: check accepted page bytes, stall at random, hold off twice
	initial begin
		int stall_left;
		int hold_left;
		page_byte_t got;
		stall_left = 0;
		hold_left  = 0;
		page_bytes.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (page_bytes.valid && page_bytes.ready) begin
				got.column_byte   = page_bytes.column_byte;
				got.page_number   = page_bytes.page_number;
				got.column_number = page_bytes.column_number;
				got.last_of_run   = page_bytes.last_of_run;
				got.last_of_frame = page_bytes.last_of_frame;
				sb.check_result(got);
				if ((sb.checked == 100 || sb.checked == 300) && hold_left == 0) begin
					hold_left = LONG_HOLD;
					long_holds++;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				page_bytes.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				page_bytes.ready <= 1'b0;
			end else begin
				stall_left = pick_gap();
				page_bytes.ready <= (stall_left == 0);
				if (stall_left > 0) stall_left--;
			end
		end
	end

	initial begin
		logic [7:0] directed[$];
		sb         = new();
		no_idle    = 1'b0;
		bytes_sent = 0;
		long_holds = 0;
		bitmap.valid       = 1'b0;
		bitmap.bitmap_byte = 8'h00;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// field extremes, single pixels at both ends, alternating patterns
		directed = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h55, 8'hAA, 8'h7F, 8'hFE};
		for (int i = 0; i < 8; i++) directed.push_back(8'h80 >> i);
		for (int i = 0; i < 8; i++) directed.push_back(~(8'h01 << i));
		foreach (directed[i]) send_byte(directed[i]);

		// random image data across several bands
		while (bytes_sent < TOTAL_ITEMS) begin
			if (bytes_sent % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
			send_byte(pick_byte());
		end
		bitmap.valid <= 1'b0;
		no_idle = 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("%0d bitmap bytes sent, %0d page bytes checked", bytes_sent, sb.checked);
		$display("%0d frame ends seen, %0d long output holds", sb.frame_ends, long_holds);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#10ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule
